@@ src/psu_pkg.sv @@
// Shared constants, codes and item types of the PNG scanline unfilter.
`timescale 1ns / 1ps

package psu_pkg;

    localparam int MAX_ROW_BYTES = 65536;
    localparam int COL_W         = $clog2(MAX_ROW_BYTES);
    localparam int ROW_BYTES_W   = 17;
    localparam int BPP_W         = 3;
    localparam int HEIGHT_W      = 15;
    localparam int CFG_W         = 17;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_BPP       = 4;
    localparam int TAP_W         = $clog2(MAX_BPP);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BPP       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    // Filter type codes.
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam int CQ_DEPTH = 4;
    localparam int RQ_DEPTH = 4;

    // One data byte, classified and positioned by the front end.
    typedef struct packed {
        logic [7:0]       data;
        logic [COL_W-1:0] col;
        logic [2:0]       filter;
        logic             bad;
        logic             row_end;
        logic             image_end;
        logic             first_row;
        logic             left_ok;
        logic [TAP_W-1:0] tap;
    } cmd_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
        logic       image_end;
        logic       bad;
    } result_t;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [9:0]         pa;
        logic [9:0]         pb;
        logic [9:0]         pc;
        // With p = a + b - c: |p - a| = |b - c|, |p - b| = |a - c|, |p - c| = |a + b - 2c|.
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
        pa = da[10] ? 10'(-da) : 10'(da);
        pb = db[10] ? 10'(-db) : 10'(db);
        pc = dc[10] ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc)
            return a;
        else if (pb <= pc)
            return b;
        else
            return c;
    endfunction

endpackage

@@ src/psu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/psu_front.sv @@
// Front end: configuration registers, filter-type capture and row/column tracking.
`timescale 1ns / 1ps

module psu_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [psu_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          push,
    input  logic [7:0]                    stream_byte,
    output logic                          full,
    input  logic                          cq_full,
    output logic                          cq_push,
    output psu_pkg::cmd_t                 cq_cmd
);

    logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_reg;
    logic [psu_pkg::BPP_W-1:0]       bpp_reg;
    logic [psu_pkg::HEIGHT_W-1:0]    height_reg;

    logic [psu_pkg::COL_W-1:0]    col_reg;
    logic [psu_pkg::COL_W-1:0]    col_next;
    logic [psu_pkg::HEIGHT_W-1:0] row_reg;
    logic [psu_pkg::HEIGHT_W-1:0] row_next;
    logic [2:0]                   filter_reg;
    logic [2:0]                   filter_next;
    logic                         awaiting_reg;
    logic                         awaiting_next;
    logic                         bad_reg;
    logic                         bad_next;

    logic [psu_pkg::ROW_BYTES_W-1:0] eff_rb;
    logic [psu_pkg::HEIGHT_W-1:0]    eff_h;
    logic [psu_pkg::TAP_W-1:0]       tap;
    logic [psu_pkg::BPP_W-1:0]       eff_bpp;
    logic [psu_pkg::COL_W-1:0]       x;
    logic                            at_end;
    logic                            last_row;
    logic                            accept;

    always_comb
    begin
        if (row_bytes_reg == '0)
            eff_rb = psu_pkg::ROW_BYTES_W'(1);
        else if (row_bytes_reg > psu_pkg::ROW_BYTES_W'(psu_pkg::MAX_ROW_BYTES))
            eff_rb = psu_pkg::ROW_BYTES_W'(psu_pkg::MAX_ROW_BYTES);
        else
            eff_rb = row_bytes_reg;

        eff_h = (height_reg == '0) ? psu_pkg::HEIGHT_W'(1) : height_reg;

        if (bpp_reg == '0)
            tap = '0;
        else if (bpp_reg > psu_pkg::BPP_W'(psu_pkg::MAX_BPP))
            tap = psu_pkg::TAP_W'(psu_pkg::MAX_BPP - 1);
        else
            tap = psu_pkg::TAP_W'(bpp_reg - psu_pkg::BPP_W'(1));
        eff_bpp = psu_pkg::BPP_W'({1'b0, tap}) + psu_pkg::BPP_W'(1);

        // A column past a narrowed row width is pinned to the last column.
        if ({1'b0, col_reg} >= eff_rb)
            x = psu_pkg::COL_W'(eff_rb - psu_pkg::ROW_BYTES_W'(1));
        else
            x = col_reg;

        at_end   = ({1'b0, x} + psu_pkg::ROW_BYTES_W'(1)) >= eff_rb;
        last_row = at_end
                && (({1'b0, row_reg} + 16'd1) >= {1'b0, eff_h});
    end

    assign full    = !awaiting_reg && cq_full;
    assign accept  = push && !full;
    assign cq_push = accept && !awaiting_reg;

    always_comb
    begin
        cq_cmd.data      = stream_byte;
        cq_cmd.col       = x;
        cq_cmd.filter    = filter_reg;
        cq_cmd.bad       = bad_reg;
        cq_cmd.row_end   = at_end;
        cq_cmd.image_end = last_row;
        cq_cmd.first_row = (row_reg == '0);
        cq_cmd.left_ok   = x >= psu_pkg::COL_W'(eff_bpp);
        cq_cmd.tap       = tap;
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        filter_next   = filter_reg;
        awaiting_next = awaiting_reg;
        bad_next      = bad_reg;
        if (accept)
        begin
            if (awaiting_reg)
            begin
                bad_next      = stream_byte > 8'd4;
                filter_next   = bad_next ? psu_pkg::FILT_NONE : stream_byte[2:0];
                awaiting_next = 1'b0;
                col_next      = '0;
            end
            else if (at_end)
            begin
                awaiting_next = 1'b1;
                col_next      = '0;
                row_next      = last_row ? '0 : row_reg + psu_pkg::HEIGHT_W'(1);
            end
            else
            begin
                col_next = x + psu_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= psu_pkg::ROW_BYTES_W'(1);
            bpp_reg       <= psu_pkg::BPP_W'(1);
            height_reg    <= psu_pkg::HEIGHT_W'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            filter_reg    <= psu_pkg::FILT_NONE;
            awaiting_reg  <= 1'b1;
            bad_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    psu_pkg::REG_ROW_BYTES: row_bytes_reg <= cfg_data[psu_pkg::ROW_BYTES_W-1:0];
                    psu_pkg::REG_BPP:       bpp_reg       <= cfg_data[psu_pkg::BPP_W-1:0];
                    psu_pkg::REG_HEIGHT:    height_reg    <= cfg_data[psu_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            filter_reg   <= filter_next;
            awaiting_reg <= awaiting_next;
            bad_reg      <= bad_next;
        end
    end

endmodule

@@ src/psu_cmd_queue.sv @@
// Short flip-flop queue of classified data bytes between front and back end.
`timescale 1ns / 1ps

module psu_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  psu_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output psu_pkg::cmd_t head
);

    localparam int PTR_W = $clog2(psu_pkg::CQ_DEPTH);

    psu_pkg::cmd_t    slot_reg [psu_pkg::CQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full  = count_reg == (PTR_W + 1)'(psu_pkg::CQ_DEPTH);
    assign valid = count_reg != '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (PTR_W + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (PTR_W + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

@@ src/psu_back.sv @@
// Back end: line-store read, filter reconstruction, neighbor history and result queue.
`timescale 1ns / 1ps

module psu_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cq_valid,
    input  psu_pkg::cmd_t             cq_head,
    output logic                      cq_pop,
    output logic                      ram_re,
    output logic [psu_pkg::COL_W-1:0] ram_raddr,
    input  logic [7:0]                ram_rdata,
    output logic                      ram_we,
    output logic [psu_pkg::COL_W-1:0] ram_waddr,
    output logic [7:0]                ram_wdata,
    input  logic                      pop,
    output logic                      empty,
    output psu_pkg::result_t          result
);

    localparam int RPTR_W = $clog2(psu_pkg::RQ_DEPTH);

    logic          s1_valid_reg;
    psu_pkg::cmd_t s1_cmd_reg;
    logic          fwd_reg;
    logic [7:0]    fwd_data_reg;
    logic [7:0]    left_reg  [psu_pkg::MAX_BPP];
    logic [7:0]    above_reg [psu_pkg::MAX_BPP];

    psu_pkg::result_t  rq_reg [psu_pkg::RQ_DEPTH];
    logic [RPTR_W-1:0] rq_wr_reg;
    logic [RPTR_W-1:0] rq_rd_reg;
    logic [RPTR_W:0]   rq_count_reg;
    logic [RPTR_W:0]   rq_count_next;

    logic       rq_full;
    logic       s1_done;
    logic       rq_pop;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [8:0] ab_sum;
    logic [7:0] pred;
    logic [7:0] v;

    assign rq_full = rq_count_reg == (RPTR_W + 1)'(psu_pkg::RQ_DEPTH);
    assign empty   = rq_count_reg == '0;
    assign rq_pop  = pop && !empty;
    assign result  = rq_reg[rq_rd_reg];

    assign s1_done = s1_valid_reg && !rq_full;
    assign cq_pop  = cq_valid && (!s1_valid_reg || s1_done);

    assign ram_re    = cq_pop;
    assign ram_raddr = cq_head.col;
    assign ram_we    = s1_done;
    assign ram_waddr = s1_cmd_reg.col;
    assign ram_wdata = v;

    always_comb
    begin
        // The byte above is zero on the first row; else it comes from the store, or straight
        // from the write that landed on the same column in the cycle of the read.
        if (s1_cmd_reg.first_row)
            b = 8'h00;
        else if (fwd_reg)
            b = fwd_data_reg;
        else
            b = ram_rdata;
        a = s1_cmd_reg.left_ok ? left_reg[s1_cmd_reg.tap] : 8'h00;
        c = (s1_cmd_reg.left_ok && !s1_cmd_reg.first_row) ? above_reg[s1_cmd_reg.tap] : 8'h00;
        ab_sum = {1'b0, a} + {1'b0, b};

        case (s1_cmd_reg.filter)
            psu_pkg::FILT_SUB:   pred = a;
            psu_pkg::FILT_UP:    pred = b;
            psu_pkg::FILT_AVG:   pred = ab_sum[8:1];
            psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pick(a, b, c);
            default:             pred = 8'h00;
        endcase
        v = s1_cmd_reg.data + pred;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cq_pop)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cq_pop)
        begin
            s1_cmd_reg   <= cq_head;
            fwd_reg      <= s1_done && (s1_cmd_reg.col == cq_head.col);
            fwd_data_reg <= v;
        end
        if (s1_done)
        begin
            for (int i = psu_pkg::MAX_BPP - 1; i > 0; i--)
            begin
                left_reg[i]  <= left_reg[i-1];
                above_reg[i] <= above_reg[i-1];
            end
            left_reg[0]  <= v;
            above_reg[0] <= b;
            rq_reg[rq_wr_reg] <= '{pixel: v, row_end: s1_cmd_reg.row_end,
                                   image_end: s1_cmd_reg.image_end, bad: s1_cmd_reg.bad};
        end
    end

    always_comb
    begin
        rq_count_next = rq_count_reg;
        if (s1_done && !rq_pop)
            rq_count_next = rq_count_reg + (RPTR_W + 1)'(1);
        else if (rq_pop && !s1_done)
            rq_count_next = rq_count_reg - (RPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg    <= '0;
            rq_rd_reg    <= '0;
            rq_count_reg <= '0;
        end
        else
        begin
            if (s1_done)
                rq_wr_reg <= rq_wr_reg + RPTR_W'(1);
            if (rq_pop)
                rq_rd_reg <= rq_rd_reg + RPTR_W'(1);
            rq_count_reg <= rq_count_next;
        end
    end

endmodule

@@ src/png_scanline_unfilter.sv @@
// Top level of the PNG scanline unfilter: front end, command queue, back end, line store.
//
//  Channel   Direction  Handshake           Fields
//  input     in         push / full         stream_byte
//  result    out        empty / pop         pixel_byte, row_end, image_end, bad_filter
//  config    in         cfg_write           cfg_index, cfg_data
//
// One item per cycle is sustained unless the result queue is full; a data item's result
// goes from the command queue through the line-store read and reconstruction stage into
// the result queue. The line-store read is issued as an item leaves the command queue,
// and a write to the same column in that cycle is forwarded. Filter-type items give no
// result and always enter. Reset needs no clearing pass: the first row ignores its reads.
// full rises only when the four-entry command queue is full behind a stalled result queue.
`timescale 1ns / 1ps

module png_scanline_unfilter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [psu_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    stream_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    pixel_byte,
    output logic                          row_end,
    output logic                          image_end,
    output logic                          bad_filter
);

    logic                      cq_push;
    logic                      cq_full;
    logic                      cq_pop;
    logic                      cq_valid;
    psu_pkg::cmd_t             cq_cmd;
    psu_pkg::cmd_t             cq_head;
    logic                      ram_re;
    logic                      ram_we;
    logic [psu_pkg::COL_W-1:0] ram_raddr;
    logic [psu_pkg::COL_W-1:0] ram_waddr;
    logic [7:0]                ram_rdata;
    logic [7:0]                ram_wdata;
    psu_pkg::result_t          result;

    psu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .stream_byte (stream_byte),
        .full        (full),
        .cq_full     (cq_full),
        .cq_push     (cq_push),
        .cq_cmd      (cq_cmd)
    );

    psu_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cq_push),
        .push_cmd (cq_cmd),
        .full     (cq_full),
        .pop      (cq_pop),
        .valid    (cq_valid),
        .head     (cq_head)
    );

    psu_ram #(
        .WIDTH (8),
        .DEPTH (psu_pkg::MAX_ROW_BYTES)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    psu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cq_valid  (cq_valid),
        .cq_head   (cq_head),
        .cq_pop    (cq_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    assign pixel_byte = result.pixel;
    assign row_end    = result.row_end;
    assign image_end  = result.image_end;
    assign bad_filter = result.bad;

    // The last byte of an image is always the last byte of its row.
    a_image_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && image_end |-> row_end)
        else $error("image_end without row_end");

    // A data item is never pushed into a full command queue.
    a_cq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cq_push |-> !cq_full)
        else $error("command queue overflow");

    // The back end only takes an item that is waiting.
    a_cq_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cq_pop |-> cq_valid)
        else $error("command queue underflow");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the PNG scanline unfilter: predicted pixels checked against the block.
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic [7:0] pixel;
        logic       row_end;
        logic       image_end;
        logic       bad;
    } pixel_t;

    // Tracks the unfilter state and holds the pixels still owed by the block.
    class pixel_ledger;
        logic [psu_pkg::ROW_BYTES_W-1:0] width_reg;
        logic [psu_pkg::BPP_W-1:0]       bpp_reg;
        logic [psu_pkg::HEIGHT_W-1:0]    height_reg;
        logic [7:0]                      line_mem [psu_pkg::MAX_ROW_BYTES];
        logic [7:0]                      left_hist [4];
        logic [7:0]                      up_hist [4];
        int                              col;
        int                              row;
        logic [2:0]                      filt;
        bit                              want_filter;
        bit                              row_bad;
        pixel_t                          pending_pixels [$];
        int                              mismatches;
        int                              pixels_checked;
        int                              images_done;
        int                              bad_rows;

        function new();
            width_reg = 1;
            bpp_reg = 1;
            height_reg = 1;
            foreach (line_mem[i]) line_mem[i] = 8'h00;
            foreach (left_hist[i]) left_hist[i] = 8'h00;
            foreach (up_hist[i]) up_hist[i] = 8'h00;
            col = 0;
            row = 0;
            filt = psu_pkg::FILT_NONE;
            want_filter = 1'b1;
            row_bad = 1'b0;
            mismatches = 0;
            pixels_checked = 0;
            images_done = 0;
            bad_rows = 0;
        endfunction

        function int row_width();
            if (width_reg == 0) return 1;
            if (width_reg > psu_pkg::MAX_ROW_BYTES) return psu_pkg::MAX_ROW_BYTES;
            return int'(width_reg);
        endfunction

        function int pixel_step();
            if (bpp_reg == 0) return 1;
            if (bpp_reg > psu_pkg::MAX_BPP) return psu_pkg::MAX_BPP;
            return int'(bpp_reg);
        endfunction

        function int rows_per_image();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function void write_reg(logic [psu_pkg::CFG_IDX_W-1:0] idx,
                                logic [psu_pkg::CFG_W-1:0] val);
            case (idx)
                psu_pkg::REG_ROW_BYTES: width_reg = val[psu_pkg::ROW_BYTES_W-1:0];
                psu_pkg::REG_BPP:       bpp_reg = val[psu_pkg::BPP_W-1:0];
                psu_pkg::REG_HEIGHT:    height_reg = val[psu_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function int paeth_choice(int a, int b, int c);
            int p;
            int pa;
            int pb;
            int pc;
            p = a + b - c;
            pa = (p - a < 0) ? a - p : p - a;
            pb = (p - b < 0) ? b - p : p - b;
            pc = (p - c < 0) ? c - p : p - c;
            if (pa <= pb && pa <= pc) return a;
            if (pb <= pc) return b;
            return c;
        endfunction

        // Accepted stream item: either a row's filter type or one filtered byte.
        function void take_stream_byte(logic [7:0] sbyte);
            int     w;
            int     step;
            int     x;
            int     a;
            int     b;
            int     c;
            int     v;
            pixel_t p;
            if (want_filter) begin
                row_bad = sbyte > 8'(psu_pkg::FILT_PAETH);
                filt = row_bad ? psu_pkg::FILT_NONE : sbyte[2:0];
                want_filter = 1'b0;
                col = 0;
                foreach (left_hist[i]) left_hist[i] = 8'h00;
                foreach (up_hist[i]) up_hist[i] = 8'h00;
                if (row_bad) bad_rows++;
                return;
            end
            w = row_width();
            step = pixel_step();
            x = (col >= w) ? w - 1 : col;
            b = (row == 0) ? 0 : int'(line_mem[x]);
            a = (x >= step) ? int'(left_hist[step-1]) : 0;
            c = (x >= step && row != 0) ? int'(up_hist[step-1]) : 0;
            v = int'(sbyte);
            case (filt)
                psu_pkg::FILT_SUB:   v += a;
                psu_pkg::FILT_UP:    v += b;
                psu_pkg::FILT_AVG:   v += (a + b) / 2;
                psu_pkg::FILT_PAETH: v += paeth_choice(a, b, c);
                default: ;
            endcase
            line_mem[x] = v[7:0];
            for (int i = 3; i > 0; i--) begin
                left_hist[i] = left_hist[i-1];
                up_hist[i] = up_hist[i-1];
            end
            left_hist[0] = v[7:0];
            up_hist[0] = b[7:0];
            p.pixel = v[7:0];
            p.row_end = (x + 1 >= w);
            p.image_end = p.row_end && (row + 1 >= rows_per_image());
            p.bad = row_bad;
            pending_pixels.push_back(p);
            if (p.row_end) begin
                want_filter = 1'b1;
                col = 0;
                row = p.image_end ? 0 : row + 1;
            end else begin
                col = x + 1;
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("mismatch at pixel %0d: %s", pixels_checked, msg);
        endtask

        task check_pixel(logic [7:0] px, logic re, logic ie, logic bf);
            pixel_t e;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel %02h", px));
                return;
            end
            e = pending_pixels.pop_front();
            if (px !== e.pixel)
                report_mismatch($sformatf("pixel_byte %02h, expected %02h", px, e.pixel));
            if (re !== e.row_end)
                report_mismatch($sformatf("row_end %b, expected %b", re, e.row_end));
            if (ie !== e.image_end)
                report_mismatch($sformatf("image_end %b, expected %b", ie, e.image_end));
            if (bf !== e.bad)
                report_mismatch($sformatf("bad_filter %b, expected %b", bf, e.bad));
            pixels_checked++;
            if (e.image_end) images_done++;
        endtask
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_write;
    logic [psu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [psu_pkg::CFG_W-1:0]     cfg_data;
    logic                          push;
    logic                          full;
    logic [7:0]                    stream_byte;
    logic                          empty;
    logic                          pop;
    logic [7:0]                    pixel_byte;
    logic                          row_end;
    logic                          image_end;
    logic                          bad_filter;

    pixel_ledger ledger;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          bytes_sent = 0;

    // Five short rows, one per filter type, three bytes wide with the left neighbor one back.
    localparam logic [7:0] FILTER_ROWS [0:19] = '{
        {5'd0, psu_pkg::FILT_NONE},  8'h00, 8'hFF, 8'h80,
        {5'd0, psu_pkg::FILT_SUB},   8'hFF, 8'h7F, 8'h01,
        {5'd0, psu_pkg::FILT_UP},    8'h01, 8'h80, 8'hFF,
        {5'd0, psu_pkg::FILT_AVG},   8'hFF, 8'h00, 8'h80,
        {5'd0, psu_pkg::FILT_PAETH}, 8'hF0, 8'hFF, 8'h10
    };

    png_scanline_unfilter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .stream_byte (stream_byte),
        .empty       (empty),
        .pop         (pop),
        .pixel_byte  (pixel_byte),
        .row_end     (row_end),
        .image_end   (image_end),
        .bad_filter  (bad_filter)
    );

    always #5 clk = ~clk;

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        stream_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        ledger.take_stream_byte(b);
        bytes_sent++;
    endtask

    // Filter-type items give no result, so the task still idles after the last pixel is checked.
    task automatic wait_idle();
        push <= 1'b0;
        while (ledger.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_format(input logic [psu_pkg::CFG_W-1:0] width,
                              input logic [psu_pkg::CFG_W-1:0] bpp,
                              input logic [psu_pkg::CFG_W-1:0] height);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= psu_pkg::REG_ROW_BYTES;
        cfg_data <= width;
        @(posedge clk);
        ledger.write_reg(psu_pkg::REG_ROW_BYTES, width);
        cfg_index <= psu_pkg::REG_BPP;
        cfg_data <= bpp;
        @(posedge clk);
        ledger.write_reg(psu_pkg::REG_BPP, bpp);
        cfg_index <= psu_pkg::REG_HEIGHT;
        cfg_data <= height;
        @(posedge clk);
        ledger.write_reg(psu_pkg::REG_HEIGHT, height);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [7:0] pick_filter();
        if ($urandom_range(99) < 86)
            return 8'($urandom_range(psu_pkg::FILT_PAETH));
        return 8'($urandom_range(255, psu_pkg::FILT_PAETH + 1));
    endfunction

    function automatic logic [7:0] pick_data();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 8'h00;
        if (r < 20) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_image();
        int rows;
        int w;
        rows = ledger.rows_per_image();
        w = ledger.row_width();
        for (int r = 0; r < rows; r++) begin
            push_byte(pick_filter());
            for (int c = 0; c < w; c++) push_byte(pick_data());
        end
    endtask

    task automatic send_rows(input int rows, input int bytes);
        for (int r = 0; r < rows; r++) begin
            push_byte(pick_filter());
            for (int c = 0; c < bytes; c++) push_byte(pick_data());
        end
    endtask

    // Whole images only, so every row above has been written before it is read.
    task automatic random_phase(input int idle_in, input int stall_out, input int goal);
        int start;
        int r;
        int width;
        send_idle_pct = idle_in;
        recv_stall_pct = stall_out;
        start = bytes_sent;
        while (bytes_sent - start < goal) begin
            r = $urandom_range(99);
            width = (r < 6) ? 0 : (r < 85) ? $urandom_range(1, 12) : $urandom_range(13, 80);
            set_format(psu_pkg::CFG_W'(width), psu_pkg::CFG_W'($urandom_range(0, 7)),
                       psu_pkg::CFG_W'($urandom_range(0, 6)));
            repeat ($urandom_range(1, 2)) send_image();
        end
    endtask

    initial begin
        pop = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                ledger.check_pixel(pixel_byte, row_end, image_end, bad_filter);
            pop <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        ledger = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = psu_pkg::REG_ROW_BYTES;
        cfg_data = '0;
        push = 1'b0;
        stream_byte = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset format: one byte per row, one row per image.
        push_byte({5'd0, psu_pkg::FILT_NONE});
        push_byte(8'hFF);
        // Zero in every register acts as one; unknown filter types at both ends.
        set_format(0, 0, 0);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'(psu_pkg::FILT_PAETH + 1));
        push_byte(8'h33);
        set_format(3, 1, 5);
        foreach (FILTER_ROWS[i]) push_byte(FILTER_ROWS[i]);

        random_phase(0, 0, 300);
        random_phase(68, 0, 300);
        random_phase(0, 68, 300);
        random_phase(24, 24, 300);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        // Widest row register: the start of a row, which ends once the width is narrowed.
        set_format(17'h1FFFF, 4, 1);
        send_rows(1, 6);
        set_format(3, 4, 1);
        push_byte(pick_data());
        // Tallest image register: a few rows, and the image ends once the height is lowered.
        set_format(1, 5, 15'h7FFF);
        send_rows(3, 1);
        set_format(1, 5, 4);
        send_rows(1, 1);

        wait_idle();
        $display("run covered %0d stream items, %0d pixels checked in %0d images",
                 bytes_sent, ledger.pixels_checked, ledger.images_done);
        $display("%0d rows carried an unknown filter type; widest and tallest formats began mid-image",
                 ledger.bad_rows);
        if (ledger.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
